/* sv/nec_ir_pkg.sv */
`default_nettype none

package nec_ir_pkg;

   localparam int DUR_W    = 16;
   localparam int MARGIN_W = 12;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int DATA_BITS  = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_MARK_MIN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_MARK_MAX  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_SPACE_MIN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_SPACE_MAX = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_MARGIN       = 3'd4;

   localparam logic [DUR_W-1:0]    RST_HEADER_MARK_MIN  = 16'd20000;
   localparam logic [DUR_W-1:0]    RST_HEADER_MARK_MAX  = 16'd25000;
   localparam logic [DUR_W-1:0]    RST_HEADER_SPACE_MIN = 16'd10000;
   localparam logic [DUR_W-1:0]    RST_HEADER_SPACE_MAX = 16'd12500;
   localparam logic [MARGIN_W-1:0] RST_ONE_MARGIN       = 12'd56;

   localparam logic [7:0] BYTE_ALL_ONES = 8'hFF;

   // header windows, all bounds exclusive
   typedef struct packed {
      logic [DUR_W-1:0] mark_min;
      logic [DUR_W-1:0] mark_max;
      logic [DUR_W-1:0] space_min;
      logic [DUR_W-1:0] space_max;
   } window_type;

   // one classified edge handed from front to back
   typedef struct packed {
      logic             header;
      logic             shift;
      logic             emit;
      logic [DUR_W-1:0] mark;
      logic [DUR_W-1:0] space;
   } edge_type;

endpackage

`default_nettype wire

/* sv/nec_ir_front.sv */
`default_nettype none

module nec_ir_front #(
   parameter int FRAME_EDGES = 65
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_valid,
   output logic                            req_stall,
   input  wire  [nec_ir_pkg::DUR_W-1:0]    req_duration,
   input  nec_ir_pkg::window_type          window,
   input  wire                             queue_full,
   output logic                            push,
   output nec_ir_pkg::edge_type            push_edge
);

   localparam int POS_W = $clog2(FRAME_EDGES);

   logic [nec_ir_pkg::DUR_W-1:0] last_ff, last_in;
   logic [POS_W-1:0]             pos_ff, pos_in;
   logic [POS_W:0]               count;
   logic                         header;
   logic                         accept;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   always_comb begin
      header = (last_ff > window.mark_min) && (last_ff < window.mark_max) &&
               (req_duration > window.space_min) && (req_duration < window.space_max);
      count  = {1'b0, pos_ff} + (POS_W+1)'(1);

      push_edge.header = header;
      push_edge.shift  = !header && pos_ff[0] &&
                         (int'(pos_ff >> 1) < nec_ir_pkg::DATA_BITS);
      push_edge.emit   = !header && (count == (POS_W+1)'(FRAME_EDGES));
      push_edge.mark   = last_ff;
      push_edge.space  = req_duration;
      push             = accept;

      last_in = last_ff;
      pos_in  = pos_ff;
      if (accept) begin
         if (header) begin
            last_in = '0;
            pos_in  = '0;
         end else begin
            last_in = req_duration;
            pos_in  = push_edge.emit ? '0 : POS_W'(count);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= '0;
         pos_ff  <= '0;
      end else begin
         last_ff <= last_in;
         pos_ff  <= pos_in;
      end
   end

endmodule

`default_nettype wire

/* sv/nec_ir_fifo.sv */
`default_nettype none

module nec_ir_fifo (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push,
   input  nec_ir_pkg::edge_type  push_edge,
   output logic                  full,
   input  wire                   pop,
   output logic                  pop_valid,
   output nec_ir_pkg::edge_type  pop_edge
);

   nec_ir_pkg::edge_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff,  count_in;
   logic       do_pop;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_edge  = slot_ff[rd_ptr_ff];
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = push   ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_edge;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("queue written while full");

endmodule

`default_nettype wire

/* sv/nec_ir_back.sv */
`default_nettype none

module nec_ir_back #(
   parameter int FRAME_EDGES = 65,
   parameter int UNIT_TICKS  = 25
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                edge_valid,
   input  nec_ir_pkg::edge_type               edge_in,
   output logic                               edge_pop,
   input  wire  [nec_ir_pkg::MARGIN_W-1:0]    one_margin,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output logic                               rsp_status,
   output logic [15:0]                        rsp_address,
   output logic [7:0]                         rsp_command
);

   localparam int DUR_W   = nec_ir_pkg::DUR_W;
   // exact divide by UNIT_TICKS via rounded-up reciprocal
   localparam int SHIFT   = DUR_W + $clog2(UNIT_TICKS);
   localparam longint unsigned RECIP_FULL =
      ((64'd1 << SHIFT) + longint'(UNIT_TICKS) - 64'd1) / longint'(UNIT_TICKS);
   localparam int PROD_W  = 2 * DUR_W + 1;
   localparam logic [DUR_W:0] RECIP = (DUR_W+1)'(RECIP_FULL);
   localparam int UNIT_W  = $clog2(((1 << DUR_W) - 1) / UNIT_TICKS + 1);
   localparam int CMP_W   =
      ((UNIT_W > nec_ir_pkg::MARGIN_W) ? UNIT_W : nec_ir_pkg::MARGIN_W) + 1;
   localparam int GOT_RAW = FRAME_EDGES / 2;
   localparam int GOT     =
      (GOT_RAW < nec_ir_pkg::DATA_BITS) ? GOT_RAW : nec_ir_pkg::DATA_BITS;
   localparam int DROP    = nec_ir_pkg::DATA_BITS - GOT;

   // stage A: scaled durations
   logic              a_valid_ff, a_valid_in;
   logic              a_header_ff, a_shift_ff, a_emit_ff;
   logic [UNIT_W-1:0] a_mark_ff, a_space_ff;
   logic [PROD_W-1:0] mark_prod, space_prod;

   // stage B: bit shifter and result register
   logic [nec_ir_pkg::DATA_BITS-1:0] bits_ff, bits_in, bits_next, word;
   logic [CMP_W-1:0]  diff;
   logic              one_bit;
   logic              out_free, commit, a_load;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              status_in;
   logic [15:0]       address_in;
   logic [7:0]        command_in;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign commit   = a_valid_ff && (!a_emit_ff || out_free);
   assign a_load   = !a_valid_ff || commit;
   assign edge_pop = a_load && edge_valid;

   always_comb begin
      mark_prod  = PROD_W'(edge_in.mark)  * PROD_W'(RECIP);
      space_prod = PROD_W'(edge_in.space) * PROD_W'(RECIP);
      a_valid_in = a_load ? edge_valid : a_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (a_load) begin
         a_header_ff <= edge_in.header;
         a_shift_ff  <= edge_in.shift;
         a_emit_ff   <= edge_in.emit;
         a_mark_ff   <= UNIT_W'(mark_prod >> SHIFT);
         a_space_ff  <= UNIT_W'(space_prod >> SHIFT);
      end
   end

   always_comb begin
      diff    = CMP_W'(a_space_ff) - CMP_W'(a_mark_ff);
      one_bit = (a_space_ff > a_mark_ff) && (diff > CMP_W'(one_margin));

      bits_next = a_shift_ff ? {one_bit, bits_ff[nec_ir_pkg::DATA_BITS-1:1]} : bits_ff;
      word      = bits_next >> DROP;

      // inverse byte must be the complement of the command byte
      if (word[31:24] == ~word[23:16]) begin
         status_in  = 1'b0;
         address_in = word[15:0];
         command_in = word[23:16];
      end else begin
         status_in  = 1'b1;
         address_in = '0;
         command_in = '0;
      end

      bits_in = bits_ff;
      if (commit) begin
         bits_in = (a_header_ff || a_emit_ff) ? '0 : bits_next;
      end

      rsp_valid_in = rsp_valid_ff;
      if (commit && a_emit_ff) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit && a_emit_ff) begin
         rsp_status  <= status_in;
         rsp_address <= address_in;
         rsp_command <= command_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         bits_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         bits_ff      <= bits_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_fail_zeroed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status) |-> (rsp_address == '0 && rsp_command == '0))
      else $error("failed frame carries nonzero payload");

   a_header_clears: assert property (@(posedge clock) disable iff (reset)
      (commit && a_header_ff) |=> (bits_ff == '0))
      else $error("header did not clear frame bits");

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      (commit && a_emit_ff) |=> rsp_valid_ff)
      else $error("emitted frame not presented");

   a_hold_blocked: assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && a_emit_ff && !out_free) |=> (a_valid_ff && a_emit_ff))
      else $error("blocked frame item lost");

endmodule

`default_nettype wire

/* sv/nec_ir_pulse_decoder.sv */
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_stall   req_duration (16b ticks of 0.4 us)
// rsp      out        rsp_valid/rsp_stall   rsp_status, rsp_address, rsp_command
// csr      in         csr_write             csr_index (3b), csr_data (16b)
//
// One request per cycle sustained while rsp_stall is low; a frame result follows the
// request that closes it through the queue, divide-by-unit multiply stage and result register.
// The per-edge state loop (previous duration, edge count) is one compare stage.
// Synchronous reset clears control state at once; no clearing pass.
// rsp_stall holds the back end; the two-entry queue then fills and raises req_stall.
`default_nettype none

module nec_ir_pulse_decoder #(
   parameter int FRAME_EDGES = 65,
   parameter int UNIT_TICKS  = 25
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire  [nec_ir_pkg::DUR_W-1:0]          req_duration,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic                                  rsp_status,
   output logic [15:0]                           rsp_address,
   output logic [7:0]                            rsp_command,
   input  wire                                   csr_write,
   input  wire  [nec_ir_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  [nec_ir_pkg::CSR_DATA_W-1:0]     csr_data
);

   // config registers; the user writes them only while idle, the block itself does not enforce it
   nec_ir_pkg::window_type               window_ff, window_in;
   logic [nec_ir_pkg::MARGIN_W-1:0]      margin_ff, margin_in;

   nec_ir_pkg::edge_type push_edge, pop_edge;
   logic                 push, pop, queue_full, pop_valid;

   always_comb begin
      window_in = window_ff;
      margin_in = margin_ff;
      if (csr_write) begin
         case (csr_index)
            nec_ir_pkg::CSR_HEADER_MARK_MIN:  window_in.mark_min  = csr_data;
            nec_ir_pkg::CSR_HEADER_MARK_MAX:  window_in.mark_max  = csr_data;
            nec_ir_pkg::CSR_HEADER_SPACE_MIN: window_in.space_min = csr_data;
            nec_ir_pkg::CSR_HEADER_SPACE_MAX: window_in.space_max = csr_data;
            nec_ir_pkg::CSR_ONE_MARGIN:
               margin_in = csr_data[nec_ir_pkg::MARGIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff.mark_min  <= nec_ir_pkg::RST_HEADER_MARK_MIN;
         window_ff.mark_max  <= nec_ir_pkg::RST_HEADER_MARK_MAX;
         window_ff.space_min <= nec_ir_pkg::RST_HEADER_SPACE_MIN;
         window_ff.space_max <= nec_ir_pkg::RST_HEADER_SPACE_MAX;
         margin_ff           <= nec_ir_pkg::RST_ONE_MARGIN;
      end else begin
         window_ff <= window_in;
         margin_ff <= margin_in;
      end
   end

   // front: header detect, edge counting, mark/space pairing
   nec_ir_front #(
      .FRAME_EDGES (FRAME_EDGES)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_duration (req_duration),
      .window       (window_ff),
      .queue_full   (queue_full),
      .push         (push),
      .push_edge    (push_edge)
   );

   nec_ir_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_edge (push_edge),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_edge  (pop_edge)
   );

   // back: unit scaling, bit decision, frame assembly, result register
   nec_ir_back #(
      .FRAME_EDGES (FRAME_EDGES),
      .UNIT_TICKS  (UNIT_TICKS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .edge_valid  (pop_valid),
      .edge_in     (pop_edge),
      .edge_pop    (pop),
      .one_margin  (margin_ff),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_status  (rsp_status),
      .rsp_address (rsp_address),
      .rsp_command (rsp_command)
   );

endmodule

`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 100ps

module testbench;

   localparam int DUR_W      = nec_ir_pkg::DUR_W;
   localparam int MARGIN_W   = nec_ir_pkg::MARGIN_W;
   localparam int CSR_IDX_W  = nec_ir_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W = nec_ir_pkg::CSR_DATA_W;
   localparam int DATA_BITS  = nec_ir_pkg::DATA_BITS;

   localparam int CLOCK_PERIOD = 12;
   localparam int FRAME_EDGES  = 65;
   localparam int UNIT_TICKS   = 25;
   // result register sits behind the queue and the multiply stage; keep some slack
   localparam int DRAIN_SLACK  = 8;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int ITEM_TARGET  = 1550;
   localparam int ITEM_CAP     = 4000;
   localparam int FRAME_TARGET = 45;
   localparam int MARGIN_MAX   = 2621;

   localparam logic STATUS_OK         = 1'b0;
   localparam logic STATUS_CHECK_FAIL = 1'b1;

   typedef struct packed {
      logic        status;
      logic [15:0] address;
      logic [7:0]  command;
   } frame_result_type;

   // ---------------------------------------------------------------- DUT I/O
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [DUR_W-1:0]      req_duration = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_status;
   logic [15:0]           rsp_address;
   logic [7:0]            rsp_command;
   logic                  csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   nec_ir_pulse_decoder #(
      .FRAME_EDGES (FRAME_EDGES),
      .UNIT_TICKS  (UNIT_TICKS)
   ) uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_duration (req_duration),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_address  (rsp_address),
      .rsp_command  (rsp_command),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------- decoder model
   // register copies, tracked as they are written
   logic [DUR_W-1:0]    cfg_mark_min  = nec_ir_pkg::RST_HEADER_MARK_MIN;
   logic [DUR_W-1:0]    cfg_mark_max  = nec_ir_pkg::RST_HEADER_MARK_MAX;
   logic [DUR_W-1:0]    cfg_space_min = nec_ir_pkg::RST_HEADER_SPACE_MIN;
   logic [DUR_W-1:0]    cfg_space_max = nec_ir_pkg::RST_HEADER_SPACE_MAX;
   logic [MARGIN_W-1:0] cfg_margin    = nec_ir_pkg::RST_ONE_MARGIN;

   // per-edge decode state
   logic [DUR_W-1:0] prev_dur   = '0;
   logic [6:0]       edge_count = '0;
   logic [31:0]      shift_bits = '0;

   frame_result_type pending_frames[$];

   // run bookkeeping
   int errors           = 0;
   int items_sent       = 0;
   int frames_predicted = 0;
   int frames_checked   = 0;
   int headers_seen     = 0;
   int settings_used    = 1;
   int cycle_count      = 0;

   // traffic shaping, percent of cycles
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_left     = 0;

   function automatic bit pair_is_one(input logic [DUR_W-1:0] mark,
                                      input logic [DUR_W-1:0] space);
      int unsigned mu, su;
      mu = mark / UNIT_TICKS;
      su = space / UNIT_TICKS;
      return (su > mu) && ((su - mu) > cfg_margin);
   endfunction

   // advance the model by one edge duration; queue a frame if one closes
   task automatic decode_pulse(input logic [DUR_W-1:0] dur);
      int unsigned      pos, cnt, got;
      logic [31:0]      word;
      frame_result_type res;
      pos = edge_count;
      if (prev_dur > cfg_mark_min && prev_dur < cfg_mark_max &&
          dur > cfg_space_min && dur < cfg_space_max) begin
         // header pair: restart, never emits even on the closing count
         edge_count = '0;
         shift_bits = '0;
         prev_dur   = '0;
         headers_seen++;
         return;
      end
      // odd position closes a mark/space pair
      if (pos % 2 == 1 && pos / 2 < DATA_BITS) begin
         shift_bits = shift_bits >> 1;
         if (pair_is_one(prev_dur, dur))
            shift_bits[31] = 1'b1;
      end
      prev_dur = dur;
      cnt = pos + 1;
      if (cnt < FRAME_EDGES) begin
         edge_count = 7'(cnt);
         return;
      end
      // short frames: right-align what was received
      got  = (cnt / 2 < DATA_BITS) ? cnt / 2 : DATA_BITS;
      word = shift_bits;
      if (got < DATA_BITS)
         word = (got == 0) ? '0 : word >> (DATA_BITS - got);
      if (int'(word[23:16]) + int'(word[31:24]) == int'(nec_ir_pkg::BYTE_ALL_ONES)) begin
         res.status  = STATUS_OK;
         res.address = word[15:0];
         res.command = word[23:16];
      end else begin
         res.status  = STATUS_CHECK_FAIL;
         res.address = '0;
         res.command = '0;
      end
      pending_frames.push_back(res);
      frames_predicted++;
      edge_count = '0;
      shift_bits = '0;
   endtask

   task automatic apply_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      case (idx)
         nec_ir_pkg::CSR_HEADER_MARK_MIN:  cfg_mark_min  = val;
         nec_ir_pkg::CSR_HEADER_MARK_MAX:  cfg_mark_max  = val;
         nec_ir_pkg::CSR_HEADER_SPACE_MIN: cfg_space_min = val;
         nec_ir_pkg::CSR_HEADER_SPACE_MAX: cfg_space_max = val;
         nec_ir_pkg::CSR_ONE_MARGIN:       cfg_margin    = val[MARGIN_W-1:0];
         default: ;
      endcase
   endtask

   // ------------------------------------------------------- result checking
   always @(posedge clock) begin
      frame_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_frames.size() == 0) begin
            $error("unexpected result: status %0d address %h command %h",
                   rsp_status, rsp_address, rsp_command);
            errors++;
         end else begin
            want = pending_frames.pop_front();
            frames_checked++;
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               errors++;
            end
            if (rsp_address !== want.address) begin
               $error("address: expected %h, got %h", want.address, rsp_address);
               errors++;
            end
            if (rsp_command !== want.command) begin
               $error("command: expected %h, got %h", want.command, rsp_command);
               errors++;
            end
         end
      end
   end

   // receiver: random stall, or a long hold-off counted down here
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // -------------------------------------------------------------- drivers
   // entered and left at a rising edge; valid stays up when no gap follows
   task automatic send_pulse(input logic [DUR_W-1:0] dur);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid    <= 1'b1;
      req_duration <= dur;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      decode_pulse(dur);
      items_sent++;
   endtask

   // stop offering and wait until every frame has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   // all five registers back to back, only while idle
   task automatic program_csrs(input logic [DUR_W-1:0] mark_min,
                               input logic [DUR_W-1:0] mark_max,
                               input logic [DUR_W-1:0] space_min,
                               input logic [DUR_W-1:0] space_max,
                               input int margin);
      logic [CSR_IDX_W-1:0]  idxs [5];
      logic [CSR_DATA_W-1:0] vals [5];
      wait_drained();
      idxs = '{nec_ir_pkg::CSR_HEADER_MARK_MIN, nec_ir_pkg::CSR_HEADER_MARK_MAX,
               nec_ir_pkg::CSR_HEADER_SPACE_MIN, nec_ir_pkg::CSR_HEADER_SPACE_MAX,
               nec_ir_pkg::CSR_ONE_MARGIN};
      vals = '{mark_min, mark_max, space_min, space_max, CSR_DATA_W'(margin)};
      csr_write <= 1'b1;
      for (int i = 0; i < 5; i++) begin
         csr_index <= idxs[i];
         csr_data  <= vals[i];
         @(posedge clock);
         apply_csr(idxs[i], vals[i]);
      end
      csr_write <= 1'b0;
      settings_used++;
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      stall_pct     = recv_pct;
   endtask

   // mostly inside the exclusive window, sometimes right on a bound
   function automatic logic [DUR_W-1:0] pick_in_window(input logic [DUR_W-1:0] lo,
                                                       input logic [DUR_W-1:0] hi);
      int r;
      r = $urandom_range(19);
      if (r == 0) return lo;
      if (r == 1) return hi;
      if (int'(hi) > int'(lo) + 1)
         return DUR_W'($urandom_range(int'(hi) - 1, int'(lo) + 1));
      return DUR_W'($urandom_range(16'hFFFF));
   endfunction

   function automatic logic [DUR_W-1:0] pick_mark();
      if ($urandom_range(9) == 0) return DUR_W'($urandom_range(4000));
      return DUR_W'($urandom_range(1800, 1000));
   endfunction

   // space aimed at the wanted bit, often right at the margin
   function automatic logic [DUR_W-1:0] pick_space(input logic [DUR_W-1:0] mark,
                                                   input bit one);
      int mu, su;
      mu = mark / UNIT_TICKS;
      if (one)
         su = mu + cfg_margin + 1 + (($urandom_range(2) == 0) ? 0 : $urandom_range(40));
      else if ($urandom_range(2) == 0)
         su = mu + cfg_margin;
      else
         su = $urandom_range(mu + cfg_margin);
      su = su * UNIT_TICKS + $urandom_range(UNIT_TICKS - 1);
      return (su > 65535) ? 16'hFFFF : DUR_W'(su);
   endfunction

   // header pair, then up to FRAME_EDGES edges: 32 mark/space pairs and a stop mark
   task automatic send_frame(input logic [15:0] addr, input logic [7:0] cmd,
                             input bit corrupt, input int data_edges);
      logic [31:0]      word;
      logic [7:0]       inv;
      logic [DUR_W-1:0] mark;
      int               sent;
      inv = ~cmd;
      if (corrupt) inv = inv ^ 8'($urandom_range(255, 1));
      word = {inv, cmd, addr};
      send_pulse(pick_in_window(cfg_mark_min, cfg_mark_max));
      send_pulse(pick_in_window(cfg_space_min, cfg_space_max));
      sent = 0;
      for (int i = 0; i < DATA_BITS && sent < data_edges; i++) begin
         mark = pick_mark();
         send_pulse(mark);
         sent++;
         if (sent < data_edges) begin
            send_pulse(pick_space(mark, word[i]));
            sent++;
         end
      end
      if (sent < data_edges) send_pulse(pick_mark());
   endtask

   task automatic send_noise(input int count);
      int r;
      repeat (count) begin
         r = $urandom_range(9);
         if (r == 0) send_pulse('0);
         else if (r == 1) send_pulse(16'hFFFF);
         else send_pulse(DUR_W'($urandom));
      end
   endtask

   // mostly clean frames, some truncated ones and some garbage
   task automatic run_traffic(input int budget);
      int stop_at, r;
      stop_at = items_sent + budget;
      while (items_sent < stop_at) begin
         r = $urandom_range(99);
         if (r < 75)
            send_frame(16'($urandom), 8'($urandom), $urandom_range(4) == 0, FRAME_EDGES);
         else if (r < 88)
            send_frame(16'($urandom), 8'($urandom), 1'b0, $urandom_range(FRAME_EDGES - 1));
         else
            send_noise($urandom_range(12, 1));
      end
   endtask

   // ---------------------------------------------------------------- tests
   // field extremes, header window bounds and the one/zero margin boundary
   task automatic test_directed_pulses();
      logic [DUR_W-1:0] seq [$];
      set_idling(0, 0);
      seq = '{16'd0, 16'hFFFF, 16'hFFFF, 16'd0,
              // mark on the lower bound: no header
              nec_ir_pkg::RST_HEADER_MARK_MIN, nec_ir_pkg::RST_HEADER_SPACE_MIN + 16'd1000,
              // just inside every bound: header
              nec_ir_pkg::RST_HEADER_MARK_MIN + 16'd1, nec_ir_pkg::RST_HEADER_SPACE_MIN + 16'd1,
              nec_ir_pkg::RST_HEADER_MARK_MAX - 16'd1, nec_ir_pkg::RST_HEADER_SPACE_MAX - 16'd1,
              // mark on the upper bound
              nec_ir_pkg::RST_HEADER_MARK_MAX, nec_ir_pkg::RST_HEADER_SPACE_MIN + 16'd1000,
              // space on either bound
              nec_ir_pkg::RST_HEADER_MARK_MIN + 16'd2000, nec_ir_pkg::RST_HEADER_SPACE_MIN,
              nec_ir_pkg::RST_HEADER_MARK_MIN + 16'd2000, nec_ir_pkg::RST_HEADER_SPACE_MAX,
              nec_ir_pkg::RST_HEADER_MARK_MIN + 16'd2000,
              nec_ir_pkg::RST_HEADER_SPACE_MIN + 16'd1000,
              // 56 mark units; space exactly margin above -> zero, one unit more -> one
              16'd1400, 16'd2800,
              16'd1400, 16'd2825};
      foreach (seq[i]) send_pulse(seq[i]);
   endtask

   task automatic test_default_frames();
      set_idling(0, 0);
      send_frame(16'h0000, 8'h00, 1'b0, FRAME_EDGES);
      send_frame(16'hFFFF, 8'hFF, 1'b0, FRAME_EDGES);
      send_frame(16'hA55A, 8'h3C, 1'b1, FRAME_EDGES);
      // next header space lands on what would be the closing count
      send_frame(16'($urandom), 8'($urandom), 1'b0, FRAME_EDGES - 2);
      send_frame(16'($urandom), 8'($urandom), 1'b0, FRAME_EDGES);
      run_traffic(120);
   endtask

   task automatic test_tight_windows();
      // one legal value per window, zero margin
      program_csrs(16'd40000, 16'd40002, 16'd60000, 16'd60002, 0);
      set_idling(72, 0);
      run_traffic(120);
   endtask

   task automatic test_max_margin();
      program_csrs(nec_ir_pkg::RST_HEADER_MARK_MIN, nec_ir_pkg::RST_HEADER_MARK_MAX,
                   nec_ir_pkg::RST_HEADER_SPACE_MIN, nec_ir_pkg::RST_HEADER_SPACE_MAX,
                   MARGIN_MAX);
      set_idling(0, 72);
      run_traffic(120);
   endtask

   task automatic test_empty_windows();
      // min above max: no header ever, frames close on the edge count alone
      program_csrs(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 100);
      set_idling(6, 6);
      run_traffic(120);
   endtask

   task automatic test_wide_windows();
      // nearly everything is a header mark; restarts are frequent
      program_csrs(16'h0000, 16'hFFFF, 16'd5000, 16'hFFFF, $urandom_range(MARGIN_MAX));
      set_idling(6, 6);
      run_traffic(100);
   endtask

   task automatic test_backpressure();
      program_csrs(nec_ir_pkg::RST_HEADER_MARK_MIN, nec_ir_pkg::RST_HEADER_MARK_MAX,
                   nec_ir_pkg::RST_HEADER_SPACE_MIN, nec_ir_pkg::RST_HEADER_SPACE_MAX,
                   nec_ir_pkg::RST_ONE_MARGIN);
      set_idling(0, 0);
      // long receiver hold while the sender keeps offering: queue fills, req_stall rises
      hold_left = 400;
      repeat (3) send_frame(16'($urandom), 8'($urandom), 1'b0, FRAME_EDGES);
      // sender pauses until all frames are back
      wait_drained();
      set_idling(72, 72);
      send_frame(16'($urandom), 8'($urandom), 1'b0, FRAME_EDGES);
   endtask

   task automatic test_random_settings();
      int mark_lo, space_lo, margin, phase;
      while ((items_sent < ITEM_TARGET || frames_predicted < FRAME_TARGET) &&
             items_sent < ITEM_CAP) begin
         mark_lo  = $urandom_range(30000, 15000);
         space_lo = $urandom_range(14000, 6000);
         margin   = ($urandom_range(1) == 0) ? $urandom_range(120)
                                              : $urandom_range(MARGIN_MAX);
         if ($urandom_range(5) == 0)
            program_csrs(16'(mark_lo), 16'(mark_lo), 16'(space_lo),
                         16'(space_lo + $urandom_range(6000, 2)), margin);
         else
            program_csrs(16'(mark_lo), 16'(mark_lo + $urandom_range(8000, 2)),
                         16'(space_lo), 16'(space_lo + $urandom_range(6000, 2)), margin);
         phase = $urandom_range(3);
         case (phase)
            0: set_idling(0, 0);
            1: set_idling(72, 0);
            2: set_idling(0, 72);
            default: set_idling(6, 6);
         endcase
         run_traffic(100);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed_pulses();
      test_default_frames();
      test_tight_windows();
      test_max_margin();
      test_empty_windows();
      test_wide_windows();
      test_backpressure();
      test_random_settings();
      wait_drained();
      $display("%0d edge durations sent, %0d frames checked, %0d header restarts",
               items_sent, frames_checked, headers_seen);
      $display("%0d register settings, mismatches: %0d", settings_used, errors);
      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

/* nec_ir_pulse_decoder.f */
sv/nec_ir_pkg.sv
sv/nec_ir_front.sv
sv/nec_ir_fifo.sv
sv/nec_ir_back.sv
sv/nec_ir_pulse_decoder.sv
bench/testbench.sv
